>>> hw/rtl/uct_pkg.sv
// uct_pkg: sizes, port-allocation constants and control/status types
// shared by the udp connection table controller, datapath and top level.
// no dependencies.
package uct_pkg;

    // table geometry
    localparam int SLOTS = 8;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int TRY_W = $clog2(SLOTS + 1);

    // ephemeral port range
    localparam logic [15:0] PORT_START = 16'd1024;
    localparam logic [15:0] PORT_LIMIT = 16'd32000;
    localparam logic [15:0] PORT_WRAP  = 16'd4096;

    // item kinds
    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_OPEN   = 1'b1;

    // beat widths
    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 24;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;        // capture the input beat
        logic advance;     // step last port to the next candidate
        logic scan_start;  // start a pass over the slots
        logic res_lookup;  // latch lookup outcome as pending result
        logic res_alloc;   // take lowest free slot, latch pending result
        logic emit;        // move pending result to the output register
    } uct_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic done;        // scan finished this cycle
        logic hit;         // scan stopped on a matching slot
        logic out_free;    // output register can take a result
    } uct_sts_t;

    // next ephemeral port after p
    function automatic logic [15:0] next_port(input logic [15:0] p);
        logic [15:0] q;
        q = p + 16'd1;
        if (q >= PORT_LIMIT)
        begin
            q = PORT_WRAP;
        end
        return q;
    endfunction

    // slot index as the three-bit result field
    function automatic logic [2:0] slot_field(input logic [IDX_W-1:0] idx);
        logic [IDX_W+2:0] ext;
        ext = {3'b000, idx};
        return ext[2:0];
    endfunction

endpackage

>>> hw/rtl/uct_ctrl.sv
// uct_ctrl: sequencing state machine for lookup and open items.
// depends on uct_pkg; drives uct_datapath through uct_cmd_t.
module uct_ctrl
    import uct_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_kind,
    output logic     in_ready,
    input  uct_sts_t sts,
    output uct_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOOK = 2'd1;
    localparam logic [1:0] ST_PORT = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [TRY_W-1:0] tries_reg, tries_next;

    assign in_ready = (state_reg == ST_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        tries_next = tries_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load       = 1'b1;
                    cmd.scan_start = 1'b1;
                    tries_next     = '0;
                    if (in_kind == KIND_OPEN)
                    begin
                        cmd.advance = 1'b1;
                        state_next  = ST_PORT;
                    end
                    else
                    begin
                        state_next = ST_LOOK;
                    end
                end
            end
            ST_LOOK:
            begin
                if (sts.done)
                begin
                    cmd.res_lookup = 1'b1;
                    state_next     = ST_EMIT;
                end
            end
            ST_PORT:
            begin
                if (sts.done)
                begin
                    // candidate taken: try the next one, bounded by slot count
                    if (sts.hit && (tries_reg < TRY_W'(SLOTS)))
                    begin
                        cmd.advance    = 1'b1;
                        cmd.scan_start = 1'b1;
                        tries_next     = tries_reg + TRY_W'(1);
                    end
                    else
                    begin
                        cmd.res_alloc = 1'b1;
                        state_next    = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            tries_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            tries_reg <= tries_next;
        end
    end

endmodule

>>> hw/rtl/uct_datapath.sv
// uct_datapath: slot memory, valid bits, scan pipeline, port register
// and result registers. depends on uct_pkg; commanded by uct_ctrl.
module uct_datapath
    import uct_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  uct_cmd_t              cmd,
    output uct_sts_t              sts,
    input  logic                  in_kind,
    input  logic [15:0]           in_dest_port,
    input  logic [15:0]           in_src_port,
    input  logic [31:0]           in_src_addr,
    input  logic [31:0]           in_remote_addr,
    input  logic [15:0]           in_remote_port,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  out_ok,
    output logic [2:0]            out_slot,
    output logic [15:0]           out_local_port
);

    localparam int ENTRY_W = 64;

    // slot store: local port, remote port, remote address
    logic [ENTRY_W-1:0] mem [SLOTS];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [SLOTS-1:0]   valid_reg;
    logic               rd_valid_reg;

    // captured item
    logic        mode_reg;
    logic [15:0] dport_reg, sport_reg, rport_reg;
    logic [31:0] saddr_reg, raddr_reg;
    logic [15:0] last_port_reg;

    // scan pipeline
    logic             run_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic             cmp_vld_reg;
    logic [IDX_W-1:0] cmp_idx_reg;

    // pending and output results
    logic        res_ok_reg;
    logic [2:0]  res_slot_reg;
    logic [15:0] res_lp_reg;
    logic        m_valid_reg;
    logic        m_ok_reg;
    logic [2:0]  m_slot_reg;
    logic [15:0] m_lp_reg;

    logic [15:0]      e_lp, e_rp;
    logic [31:0]      e_ra;
    logic             match;
    logic             cmp_last;
    logic             free_any;
    logic [IDX_W-1:0] free_idx;

    assign e_lp = rd_data_reg[15:0];
    assign e_rp = rd_data_reg[31:16];
    assign e_ra = rd_data_reg[63:32];

    // compare stage: datagram accept or port in use
    always_comb
    begin
        if (mode_reg == KIND_LOOKUP)
        begin
            match = rd_valid_reg && (e_lp == dport_reg)
                 && ((e_rp == 16'd0) || (e_rp == sport_reg))
                 && ((e_ra == 32'h0000_0000) || (e_ra == 32'hFFFF_FFFF)
                     || (e_ra == saddr_reg));
        end
        else
        begin
            match = rd_valid_reg && (e_lp == last_port_reg);
        end
    end

    assign cmp_last     = (cmp_idx_reg == IDX_W'(SLOTS - 1));
    assign sts.done     = cmp_vld_reg && (match || cmp_last);
    assign sts.hit      = cmp_vld_reg && match;
    assign sts.out_free = !m_valid_reg || out_ready;

    // lowest free slot
    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_any = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    // slot memory, registered read at the scan address
    always_ff @(posedge clk)
    begin
        if (cmd.res_alloc && free_any)
        begin
            mem[free_idx] <= {raddr_reg, rport_reg, last_port_reg};
        end
        rd_data_reg <= mem[rd_idx_reg];
    end

    // captured item fields
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            dport_reg <= in_dest_port;
            sport_reg <= in_src_port;
            saddr_reg <= in_src_addr;
            raddr_reg <= in_remote_addr;
            rport_reg <= in_remote_port;
        end
    end

    // pending result and output payload
    always_ff @(posedge clk)
    begin
        if (cmd.res_lookup)
        begin
            res_ok_reg   <= match;
            res_slot_reg <= match ? slot_field(cmp_idx_reg) : 3'd0;
            res_lp_reg   <= match ? e_lp : 16'd0;
        end
        else if (cmd.res_alloc)
        begin
            res_ok_reg   <= free_any;
            res_slot_reg <= free_any ? slot_field(free_idx) : 3'd0;
            res_lp_reg   <= free_any ? last_port_reg : 16'd0;
        end
        if (cmd.emit)
        begin
            m_ok_reg   <= res_ok_reg;
            m_slot_reg <= res_slot_reg;
            m_lp_reg   <= res_lp_reg;
        end
    end

    // control state: valid bits, port, scan, output beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            mode_reg      <= KIND_LOOKUP;
            last_port_reg <= PORT_START;
            run_reg       <= 1'b0;
            rd_idx_reg    <= '0;
            cmp_vld_reg   <= 1'b0;
            cmp_idx_reg   <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[rd_idx_reg];
            if (cmd.load)
            begin
                mode_reg <= in_kind;
            end
            if (cmd.advance)
            begin
                last_port_reg <= next_port(last_port_reg);
            end
            if (cmd.res_alloc && free_any)
            begin
                valid_reg[free_idx] <= 1'b1;
            end

            // scan issue and compare stages
            if (cmd.scan_start)
            begin
                run_reg     <= 1'b1;
                rd_idx_reg  <= '0;
                cmp_vld_reg <= 1'b0;
            end
            else if (sts.done)
            begin
                run_reg     <= 1'b0;
                cmp_vld_reg <= 1'b0;
            end
            else
            begin
                cmp_vld_reg <= run_reg;
                cmp_idx_reg <= rd_idx_reg;
                if (run_reg)
                begin
                    if (rd_idx_reg == IDX_W'(SLOTS - 1))
                    begin
                        run_reg <= 1'b0;
                    end
                    else
                    begin
                        rd_idx_reg <= rd_idx_reg + IDX_W'(1);
                    end
                end
            end

            // output beat
            if (cmd.emit)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid      = m_valid_reg;
    assign out_ok         = m_ok_reg;
    assign out_slot       = m_slot_reg;
    assign out_local_port = m_lp_reg;

endmodule

>>> hw/rtl/udp_connection_table_unit.sv
// udp_connection_table_unit: udp connection table top level, datagram
// demultiplex and ephemeral port open. depends on uct_pkg, uct_ctrl, uct_datapath.
//
//   channel  dir  tdata fields (low bit up)                          tuser
//   s_*      in   dest_port, src_port, src_addr, remote_addr,        kind
//                 remote_port (112 bits)
//   m_*      out  slot, local_port, 5 zero pad bits (24 bits)        ok
//
// a lookup does one registered memory read per slot in a scan that stops
// on the first match.
// an open scans one candidate port after another, n taken ones with n no
// more than SLOTS; a taken candidate's scan stops on its slot, a free one's covers every slot.
// reset frees all slots at once via per-slot valid bits and sets last port to 1024.
// s_tready is low while an item is in progress; a result waiting on m_tready
// holds the next item only once that item's own result is ready.
module udp_connection_table_unit
    import uct_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // dest_port, src_port, src_addr, remote_addr, remote_port
    input  logic                  s_tuser,   // kind
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // slot, local_port, zero pad
    output logic                  m_tuser    // ok
);

    uct_cmd_t    cmd;
    uct_sts_t    sts;
    logic [2:0]  out_slot;
    logic [15:0] out_local_port;

    // controller
    uct_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_kind  (s_tuser),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath
    uct_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .in_kind        (s_tuser),
        .in_dest_port   (s_tdata[15:0]),
        .in_src_port    (s_tdata[31:16]),
        .in_src_addr    (s_tdata[63:32]),
        .in_remote_addr (s_tdata[95:64]),
        .in_remote_port (s_tdata[111:96]),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_ok         (m_tuser),
        .out_slot       (out_slot),
        .out_local_port (out_local_port)
    );

    // result beat packing
    assign m_tdata = {5'b00000, out_local_port, out_slot};

endmodule
